// File: hw/rtl/json_token_scanner_macros.svh
// Assertion macros for the JSON token scanner.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef JSON_TOKEN_SCANNER_MACROS_SVH
`define JSON_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JTS_ASSERT_IMPLIES(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("json_token_scanner: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define JTS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("json_token_scanner: assertion failed");

`endif

// File: hw/rtl/jts_pkg.sv
// Shared types and constants of the JSON token scanner.
// No dependencies; used by the lexer, the result queue and the top level.
package jts_pkg;

  // Token type codes
  localparam logic [3:0] TT_LCURL    = 4'd0;
  localparam logic [3:0] TT_RCURL    = 4'd1;
  localparam logic [3:0] TT_COMMA    = 4'd2;
  localparam logic [3:0] TT_LBRACKET = 4'd3;
  localparam logic [3:0] TT_RBRACKET = 4'd4;
  localparam logic [3:0] TT_COLON    = 4'd5;
  localparam logic [3:0] TT_STRING   = 4'd6;
  localparam logic [3:0] TT_TRUE     = 4'd7;
  localparam logic [3:0] TT_FALSE    = 4'd8;
  localparam logic [3:0] TT_NULL     = 4'd9;
  localparam logic [3:0] TT_INTEGER  = 4'd10;
  localparam logic [3:0] TT_DOUBLE   = 4'd11;
  localparam logic [3:0] TT_EXP      = 4'd12;
  localparam logic [3:0] TT_END      = 4'd13;
  localparam logic [3:0] TT_ERROR    = 4'd14;

  // Default result queue depth (must be at least two)
  localparam int QUEUE_DEPTH = 4;

  // One result item as it leaves the block
  typedef struct packed {
    logic        has_char;
    logic [15:0] char_value;
    logic        token_end;
    logic [3:0]  token_type;
    logic [31:0] line_number;
    logic [15:0] error_total;
    logic        last;
  } item_t;

  // Results caused by one byte: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    item_t      first;
    item_t      second;
  } lex_out_t;

endpackage

// File: hw/rtl/jts_if.sv
// Valid/ready channel interfaces of the JSON token scanner: byte input and result output.
// No dependencies; its field widths match the item fields of jts_pkg.
interface jts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source(output valid, output byte_in, output end_of_input, input ready);
  modport sink(input valid, input byte_in, input end_of_input, output ready);
endinterface

interface jts_out_if;
  logic        valid;
  logic        ready;
  logic        has_char;
  logic [15:0] char_value;
  logic        token_end;
  logic [3:0]  token_type;
  logic [31:0] line_number;
  logic [15:0] error_total;
  logic        last;

  modport source(output valid, output has_char, output char_value, output token_end,
                 output token_type, output line_number, output error_total, output last,
                 input ready);
  modport sink(input valid, input has_char, input char_value, input token_end,
               input token_type, input line_number, input error_total, input last,
               output ready);
endinterface

// File: hw/rtl/json_token_scanner.sv
// JSON token scanner top level: input register, lexer automaton and result queue.
// Depends on jts_pkg, jts_if (jts_in_if, jts_out_if), jts_lexer and jts_out_queue.
//
// Usage: feed one character per transfer on in_ch (byte_in, end_of_input; a zero
// byte also counts as end of input). Each character yields zero, one or two result
// transfers on out_ch: token text characters (has_char) and token ends (token_end,
// token_type), each carrying the line and error counts after that character; last
// marks the final result of a character.
// Order: a character accepted on in_ch is held in the input register, stepped through
// the combinational lexer and written to the result queue; its first result then
// transfers from the queue head.
// Throughput: one character per cycle while the queue has room for two results; a
// character that closes a number and starts another token yields a second result.
// The lexer steps a held character only when the queue has room for two results.
// Stall: when out_ch.ready is low the queue fills; once fewer than two entries are
// free the held character waits and in_ch.ready drops; nothing is lost.
// Reset (rst_n low, synchronous): queue empty, lexer in start state, line count one,
// error count zero, no held character.
module json_token_scanner #(
  parameter int QUEUE_DEPTH = jts_pkg::QUEUE_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  jts_in_if.sink   in_ch,
  jts_out_if.source out_ch
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_eoi_r;
  logic              step;
  logic              room_two;
  logic [1:0]        push_count;
  jts_pkg::lex_out_t lex;
  jts_pkg::item_t    head;
  logic              head_valid;

  // step the held character when two results fit
  assign step        = in_valid_r && room_two;
  assign in_ch.ready = !in_valid_r || step;
  assign push_count  = step ? lex.count : 2'd0;

  // hold the input character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.byte_in;
      in_eoi_r  <= in_ch.end_of_input;
    end
  end

  jts_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (step),
    .byte_in      (in_byte_r),
    .end_of_input (in_eoi_r),
    .lex_o        (lex)
  );

  jts_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_count  (push_count),
    .push_first  (lex.first),
    .push_second (lex.second),
    .room_two    (room_two),
    .head_valid  (head_valid),
    .head_ready  (out_ch.ready),
    .head        (head)
  );

  // drive the result channel from the queue head
  assign out_ch.valid       = head_valid;
  assign out_ch.has_char    = head.has_char;
  assign out_ch.char_value  = head.char_value;
  assign out_ch.token_end   = head.token_end;
  assign out_ch.token_type  = head.token_type;
  assign out_ch.line_number = head.line_number;
  assign out_ch.error_total = head.error_total;
  assign out_ch.last        = head.last;

endmodule

// File: hw/rtl/jts_lexer.sv
// Lexer automaton of the JSON token scanner: one byte per step, up to two results.
// Depends on jts_pkg and json_token_scanner_macros.svh.
`include "json_token_scanner_macros.svh"

module jts_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        byte_in,
  input  logic              end_of_input,
  output jts_pkg::lex_out_t lex_o
);

  typedef enum logic [4:0] {
    ST_START    = 5'd0,
    ST_STARTNUM = 5'd1,
    ST_INNUM    = 5'd2,
    ST_INFRAC   = 5'd3,
    ST_STARTEXP = 5'd4,
    ST_EXPSIGN  = 5'd5,
    ST_INEXP    = 5'd6,
    ST_INSTR    = 5'd7,
    ST_ESCAPE   = 5'd8,
    ST_HEX      = 5'd9,
    ST_T1       = 5'd10,
    ST_T2       = 5'd11,
    ST_T3       = 5'd12,
    ST_F1       = 5'd13,
    ST_F2       = 5'd14,
    ST_F3       = 5'd15,
    ST_F4       = 5'd16,
    ST_N1       = 5'd17,
    ST_N2       = 5'd18,
    ST_N3       = 5'd19
  } state_t;

  typedef struct packed {
    logic        has_char;
    logic [15:0] char_value;
    logic        token_end;
    logic [3:0]  token_type;
  } res_t;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LCURL  = 8'h7B;
  localparam logic [7:0] CH_RCURL  = 8'h7D;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] UPPER_MSK = 8'hDF;

  state_t      state_r, state_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  hexcnt_r, hexcnt_nxt;
  logic [31:0] line_r, line_nxt;
  logic [15:0] err_r, err_nxt;

  logic [7:0]  c;
  logic        eoi;
  logic        is_dig;
  logic [7:0]  upc;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] hex_or;
  logic [7:0]  esc_code;

  // start-state decode
  logic        s_put;
  res_t        s_res;
  state_t      s_state;
  logic        s_fail;

  // keyword step decode
  logic [7:0]  kw_lower;
  state_t      kw_next;
  logic        kw_final;
  logic [3:0]  kw_type;

  res_t        p0, p1;
  logic [1:0]  n;
  logic        err_inc;

  function automatic res_t mk(input logic has, input logic [15:0] ch, input logic fin,
                              input logic [3:0] tt);
    res_t r;
    r.has_char   = has;
    r.char_value = has ? ch : 16'd0;
    r.token_end  = fin;
    r.token_type = fin ? tt : 4'd0;
    return r;
  endfunction

  // classify the byte
  assign c      = byte_in;
  assign eoi    = end_of_input || (byte_in == 8'd0);
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign upc    = c & UPPER_MSK;
  assign hex_ok = is_dig || ((upc >= CH_UP_A) && (upc <= CH_UP_F));
  assign hex_d  = is_dig ? c[3:0] : 4'(upc - CH_SEVEN);
  assign hex_or = hex_r | (16'(hex_d) << {~hexcnt_r, 2'b00});

  // map escape letters
  always_comb begin
    unique case (c)
      CH_QUOTE:  esc_code = CH_QUOTE;
      CH_BSLASH: esc_code = CH_BSLASH;
      CH_SLASH:  esc_code = CH_SLASH;
      CH_LO_B:   esc_code = CH_BS;
      CH_LO_F:   esc_code = CH_FF;
      CH_LO_N:   esc_code = CH_NL;
      CH_LO_R:   esc_code = CH_CR;
      CH_LO_T:   esc_code = CH_TAB;
      default:   esc_code = 8'd0;
    endcase
  end

  // decode a byte seen from the start state
  always_comb begin
    s_put   = 1'b0;
    s_res   = mk(1'b0, 16'd0, 1'b0, 4'd0);
    s_state = ST_START;
    s_fail  = 1'b0;
    if (eoi) begin
      s_put = 1'b1;
      s_res = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_END);
    end else begin
      unique case (c) inside
        CH_LCURL: begin
          s_put = 1'b1;
          s_res = mk(1'b1, 16'(c), 1'b1, jts_pkg::TT_LCURL);
        end
        CH_RCURL: begin
          s_put = 1'b1;
          s_res = mk(1'b1, 16'(c), 1'b1, jts_pkg::TT_RCURL);
        end
        CH_COMMA: begin
          s_put = 1'b1;
          s_res = mk(1'b1, 16'(c), 1'b1, jts_pkg::TT_COMMA);
        end
        CH_LBRK: begin
          s_put = 1'b1;
          s_res = mk(1'b1, 16'(c), 1'b1, jts_pkg::TT_LBRACKET);
        end
        CH_RBRK: begin
          s_put = 1'b1;
          s_res = mk(1'b1, 16'(c), 1'b1, jts_pkg::TT_RBRACKET);
        end
        CH_COLON: begin
          s_put = 1'b1;
          s_res = mk(1'b1, 16'(c), 1'b1, jts_pkg::TT_COLON);
        end
        CH_QUOTE: s_state = ST_INSTR;
        CH_UP_T, CH_LO_T: begin
          s_put   = 1'b1;
          s_res   = mk(1'b1, 16'(c), 1'b0, 4'd0);
          s_state = ST_T1;
        end
        CH_UP_F, CH_LO_F: begin
          s_put   = 1'b1;
          s_res   = mk(1'b1, 16'(c), 1'b0, 4'd0);
          s_state = ST_F1;
        end
        CH_UP_N, CH_LO_N: begin
          s_put   = 1'b1;
          s_res   = mk(1'b1, 16'(c), 1'b0, 4'd0);
          s_state = ST_N1;
        end
        CH_DOT, CH_MINUS, [CH_ZERO:CH_NINE]: begin
          s_put   = 1'b1;
          s_res   = mk(1'b1, 16'(c), 1'b0, 4'd0);
          s_state = ST_STARTNUM;
        end
        CH_UP_E, CH_LO_E: s_state = ST_STARTEXP;
        CH_SPACE, [CH_TAB:CH_CR]: s_put = 1'b0;
        default: begin
          s_put  = 1'b1;
          s_res  = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          s_fail = 1'b1;
        end
      endcase
    end
  end

  // expected letter and successor of each keyword state
  always_comb begin
    kw_lower = 8'd0;
    kw_next  = ST_START;
    kw_final = 1'b0;
    kw_type  = 4'd0;
    unique case (state_r)
      ST_T1: begin kw_lower = CH_LO_R; kw_next = ST_T2; end
      ST_T2: begin kw_lower = CH_LO_U; kw_next = ST_T3; end
      ST_T3: begin kw_lower = CH_LO_E; kw_final = 1'b1; kw_type = jts_pkg::TT_TRUE; end
      ST_F1: begin kw_lower = CH_LO_A; kw_next = ST_F2; end
      ST_F2: begin kw_lower = CH_LO_L; kw_next = ST_F3; end
      ST_F3: begin kw_lower = CH_LO_S; kw_next = ST_F4; end
      ST_F4: begin kw_lower = CH_LO_E; kw_final = 1'b1; kw_type = jts_pkg::TT_FALSE; end
      ST_N1: begin kw_lower = CH_LO_U; kw_next = ST_N2; end
      ST_N2: begin kw_lower = CH_LO_L; kw_next = ST_N3; end
      ST_N3: begin kw_lower = CH_LO_L; kw_final = 1'b1; kw_type = jts_pkg::TT_NULL; end
      default: kw_lower = 8'd0;
    endcase
  end

  // one automaton step
  always_comb begin
    state_nxt  = state_r;
    hex_nxt    = hex_r;
    hexcnt_nxt = hexcnt_r;
    p0         = mk(1'b0, 16'd0, 1'b0, 4'd0);
    p1         = mk(1'b0, 16'd0, 1'b0, 4'd0);
    n          = 2'd0;
    err_inc    = 1'b0;
    unique case (state_r)
      ST_STARTNUM, ST_INNUM, ST_INFRAC, ST_INEXP: begin
        if (!eoi && is_dig) begin
          p0 = mk(1'b1, 16'(c), 1'b0, 4'd0);
          n  = 2'd1;
          if (state_r == ST_STARTNUM) state_nxt = ST_INNUM;
        end else if (!eoi && c == CH_DOT &&
                     (state_r == ST_STARTNUM || state_r == ST_INNUM)) begin
          p0        = mk(1'b1, 16'(c), 1'b0, 4'd0);
          n         = 2'd1;
          state_nxt = ST_INFRAC;
        end else if (!eoi && c == CH_MINUS && state_r == ST_STARTNUM) begin
          p0        = mk(1'b1, 16'(c), 1'b0, 4'd0);
          n         = 2'd1;
          state_nxt = ST_INNUM;
        end else if (!eoi && c == CH_DOT) begin
          // second dot in a fraction or a dot in an exponent
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          n         = 2'd1;
          err_inc   = 1'b1;
          state_nxt = ST_START;
        end else begin
          // close the number and decode this byte again from start
          if (state_r == ST_INFRAC)
            p0 = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_DOUBLE);
          else if (state_r == ST_INEXP)
            p0 = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_EXP);
          else
            p0 = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_INTEGER);
          n         = s_put ? 2'd2 : 2'd1;
          p1        = s_res;
          state_nxt = s_state;
          err_inc   = s_fail;
        end
      end
      ST_STARTEXP, ST_EXPSIGN: begin
        if (!eoi && is_dig) begin
          p0        = mk(1'b1, 16'(c), 1'b0, 4'd0);
          n         = 2'd1;
          state_nxt = ST_INEXP;
        end else if (!eoi && state_r == ST_STARTEXP && (c == CH_MINUS || c == CH_PLUS)) begin
          p0        = mk(1'b1, 16'(c), 1'b0, 4'd0);
          n         = 2'd1;
          state_nxt = ST_EXPSIGN;
        end else begin
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          n         = 2'd1;
          err_inc   = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_INSTR: begin
        if (eoi) begin
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          n         = 2'd1;
          err_inc   = 1'b1;
          state_nxt = ST_START;
        end else if (c == CH_BSLASH) begin
          state_nxt = ST_ESCAPE;
        end else if (c == CH_QUOTE) begin
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_STRING);
          n         = 2'd1;
          state_nxt = ST_START;
        end else begin
          p0 = mk(1'b1, 16'(c), 1'b0, 4'd0);
          n  = 2'd1;
        end
      end
      ST_ESCAPE: begin
        if (!eoi && c == CH_LO_U) begin
          hex_nxt    = 16'd0;
          hexcnt_nxt = 2'd0;
          state_nxt  = ST_HEX;
        end else if (!eoi && esc_code != 8'd0) begin
          p0        = mk(1'b1, 16'(esc_code), 1'b0, 4'd0);
          n         = 2'd1;
          state_nxt = ST_INSTR;
        end else begin
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          n         = 2'd1;
          err_inc   = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_HEX: begin
        if (!eoi && hex_ok) begin
          hex_nxt = hex_or;
          if (hexcnt_r == 2'd3) begin
            p0         = mk(1'b1, hex_or, 1'b0, 4'd0);
            n          = 2'd1;
            hexcnt_nxt = 2'd0;
            state_nxt  = ST_INSTR;
          end else begin
            hexcnt_nxt = hexcnt_r + 2'd1;
          end
        end else begin
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          n         = 2'd1;
          err_inc   = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_T1, ST_T2, ST_T3, ST_F1, ST_F2, ST_F3, ST_F4, ST_N1, ST_N2, ST_N3: begin
        n = 2'd1;
        if (!eoi && (c | CASE_BIT) == kw_lower) begin
          p0        = mk(1'b1, 16'(c), kw_final, kw_type);
          state_nxt = kw_next;
        end else begin
          p0        = mk(1'b0, 16'd0, 1'b1, jts_pkg::TT_ERROR);
          err_inc   = 1'b1;
          state_nxt = ST_START;
        end
      end
      default: begin
        // start state and any stray encoding
        p0        = s_res;
        n         = s_put ? 2'd1 : 2'd0;
        state_nxt = s_state;
        err_inc   = s_fail;
      end
    endcase
  end

  // saturating counters
  assign line_nxt = (!eoi && c == CH_NL && line_r != '1) ? line_r + 32'd1 : line_r;
  assign err_nxt  = (err_inc && err_r != '1) ? err_r + 16'd1 : err_r;

  // assemble result items
  always_comb begin
    lex_o.count              = n;
    lex_o.first.has_char     = p0.has_char;
    lex_o.first.char_value   = p0.char_value;
    lex_o.first.token_end    = p0.token_end;
    lex_o.first.token_type   = p0.token_type;
    lex_o.first.line_number  = line_nxt;
    lex_o.first.error_total  = err_nxt;
    lex_o.first.last         = (n == 2'd1);
    lex_o.second.has_char    = p1.has_char;
    lex_o.second.char_value  = p1.char_value;
    lex_o.second.token_end   = p1.token_end;
    lex_o.second.token_type  = p1.token_type;
    lex_o.second.line_number = line_nxt;
    lex_o.second.error_total = err_nxt;
    lex_o.second.last        = 1'b1;
  end

  // hold state, advance on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      hex_r    <= 16'd0;
      hexcnt_r <= 2'd0;
      line_r   <= 32'd1;
      err_r    <= 16'd0;
    end else if (advance) begin
      state_r  <= state_nxt;
      hex_r    <= hex_nxt;
      hexcnt_r <= hexcnt_nxt;
      line_r   <= line_nxt;
      err_r    <= err_nxt;
    end
  end

  // a second result only follows a closed number
  `JTS_ASSERT_IMPLIES(a_second_after_number, clk, rst_n, lex_o.count == 2'd2,
    lex_o.first.token_end && (lex_o.first.token_type == jts_pkg::TT_INTEGER ||
    lex_o.first.token_type == jts_pkg::TT_DOUBLE || lex_o.first.token_type == jts_pkg::TT_EXP))
  // error count moves by at most one per byte
  `JTS_ASSERT_NEXT(a_err_step, clk, rst_n, advance,
    err_r == $past(err_r) || err_r == 16'($past(err_r) + 16'd1))

endmodule

// File: hw/rtl/jts_out_queue.sv
// Result queue of the JSON token scanner: takes up to two items per cycle, gives one while head_ready is high.
// Depends on jts_pkg and json_token_scanner_macros.svh.
`include "json_token_scanner_macros.svh"

module jts_out_queue #(
  parameter int DEPTH = jts_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_count,
  input  jts_pkg::item_t push_first,
  input  jts_pkg::item_t push_second,
  output logic           room_two,
  output logic           head_valid,
  input  logic           head_ready,
  output jts_pkg::item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jts_pkg::item_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [PW-1:0]  wr_ptr_p1;
  logic           pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr_p1  = ptr_inc(wr_ptr_r);
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  assign room_two   = (count_r <= CW'(DEPTH - 2));

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_count == 2'd1) wr_ptr_nxt = wr_ptr_p1;
    else if (push_count == 2'd2) wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store pushed items
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entry_r[wr_ptr_r] <= push_first;
    if (push_count == 2'd2) entry_r[wr_ptr_p1] <= push_second;
  end

  `JTS_ASSERT_IMPLIES(a_no_overfill, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `JTS_ASSERT_IMPLIES(a_push_needs_room, clk, rst_n, push_count != 2'd0, room_two)

endmodule
